@@ sv/thrwr_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// thrwr_pkg - shared types and constants of the history ring read unit
// Command codes, register indexes, field widths and the control state type.
// ---------------------------------------------------------------------------

package thrwr_pkg;

   // ring geometry default
   localparam int RING_DEPTH_DEF = 64;

   // field widths
   localparam int CMD_W      = 2;
   localparam int TIME_W     = 32;
   localparam int WORD_W     = 32;
   localparam int MAXP_W     = 7;
   localparam int CFG_W      = 27;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // stream packing
   localparam int REQ_DATA_W = 72;   // now_ms, sample_word, point limit, pad
   localparam int RSP_DATA_W = 64;   // point_word, point_time

   // register reset values and the floor of the sample interval
   localparam logic [CFG_W-1:0] INTERVAL_RESET = CFG_W'(2000);
   localparam logic [CFG_W-1:0] WINDOW_RESET   = CFG_W'(600000);
   localparam logic [CFG_W-1:0] MIN_INTERVAL   = CFG_W'(100);

   // register indexes (paddr bit 2)
   localparam logic REG_SAMPLE_INTERVAL = 1'b0;
   localparam logic REG_WINDOW          = 1'b1;

   typedef enum logic [CMD_W-1:0] {
      CMD_SAMPLE = 2'd0,
      CMD_READ   = 2'd1,
      CMD_CLEAR  = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_EMIT_RD,
      ST_EMIT_WAIT,
      ST_EMPTY
   } state_type;

endpackage

@@ sv/throttled_history_ring_window_read_unit.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// throttled_history_ring_window_read_unit - timestamped sample ring
// Throttled sample store with a time-window read, oldest point first.
// ---------------------------------------------------------------------------
// Usage:
//  req_* carries commands: tuser = cmd (sample, read window, clear),
//  tdata = now_ms, sample_word, point limit. rsp_* returns the points of a
//  read: tdata = point_word, point_time; tuser = point_valid; tlast marks
//  the final point. A read that finds nothing returns one transfer with
//  point_valid low and tlast high. Sample and clear return nothing.
//  csr_* is an APB write/read port: 0x0 sample interval, 0x4 window length.
// Timing:
//  Sample and clear are done in the idle state, which stays ready, so the
//  next command is taken right after. A read walks back one ring entry at
//  a time (ST_SCAN_RD addresses the ring memory, ST_SCAN_CHK compares the
//  registered time), then emits each point (ST_EMIT_RD reads the memory,
//  ST_EMIT_WAIT loads the output), holding the command port meanwhile. The
//  ring has a single read port, shared by the walk and the emit.
//  The output register holds a point while rsp_tready is low; the emit
//  waits until it is taken, the walk does not. Commands are taken again
//  once the last point sits in the output register.
// Reset:
//  Pointers, fill count, start and last store times clear at once; the
//  ring memory is not cleared, entries are only read after being written.
// ---------------------------------------------------------------------------

module throttled_history_ring_window_read_unit #(
   parameter int RING_DEPTH = thrwr_pkg::RING_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // command channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [31:0] now_ms, [63:32] sample_word, [70:64] point limit, [71] zero
   input  logic [thrwr_pkg::REQ_DATA_W-1:0]  req_tdata,
   // [1:0] cmd
   input  logic [thrwr_pkg::CMD_W-1:0]       req_tuser,
   // point channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [31:0] point_word, [63:32] point_time
   output logic [thrwr_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // [0] point_valid
   output logic                              rsp_tuser,
   output logic                              rsp_tlast,
   // configuration
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [thrwr_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [thrwr_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [thrwr_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                              csr_pready
);

   import thrwr_pkg::*;

   localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int CNT_W = $clog2(RING_DEPTH + 1);
   localparam int MEM_W = TIME_W + WORD_W;
   localparam logic [CNT_W:0]   DEPTH_X  = (CNT_W + 1)'(RING_DEPTH);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(RING_DEPTH);

   // request fields
   logic [TIME_W-1:0] req_now;
   logic [WORD_W-1:0] req_word;
   logic [MAXP_W-1:0] req_maxp;
   cmd_type           req_cmd;

   assign req_now  = req_tdata[TIME_W-1:0];
   assign req_word = req_tdata[TIME_W+WORD_W-1:TIME_W];
   assign req_maxp = req_tdata[TIME_W+WORD_W+MAXP_W-1:TIME_W+WORD_W];
   assign req_cmd  = cmd_type'(req_tuser);

   // configuration registers
   logic [CFG_W-1:0] interval_ff;
   logic [CFG_W-1:0] window_ff;
   logic             csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= INTERVAL_RESET;
         window_ff   <= WINDOW_RESET;
      end else if (csr_write) begin
         case (csr_paddr[2])
            REG_SAMPLE_INTERVAL: interval_ff <= csr_pwdata[CFG_W-1:0];
            REG_WINDOW:          window_ff   <= csr_pwdata[CFG_W-1:0];
            default:             ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_SAMPLE_INTERVAL: csr_prdata = CSR_DATA_W'(interval_ff);
         REG_WINDOW:          csr_prdata = CSR_DATA_W'(window_ff);
         default:             csr_prdata = '0;
      endcase
   end

   // control and status registers
   state_type         state_ff,  state_in;
   logic [PTR_W-1:0]  wp_ff,     wp_in;
   logic [CNT_W-1:0]  count_ff,  count_in;
   logic [TIME_W-1:0] start_ff,  start_in;
   logic [TIME_W-1:0] last_ff,   last_in;
   logic [TIME_W-1:0] cutoff_ff, cutoff_in;
   logic [CNT_W-1:0]  limit_ff,  limit_in;
   logic [CNT_W-1:0]  scan_ff,   scan_in;
   logic [CNT_W-1:0]  back_ff,   back_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [MEM_W-1:0]  rsp_data_ff,  rsp_data_in;
   logic              rsp_user_ff,  rsp_user_in;
   logic              rsp_last_ff,  rsp_last_in;

   // ring memory: {time, word} per entry
   logic [MEM_W-1:0]  ring_mem [RING_DEPTH];
   logic              mem_we;
   logic [PTR_W-1:0]  mem_waddr;
   logic [MEM_W-1:0]  mem_wdata;
   logic              mem_re;
   logic [PTR_W-1:0]  mem_raddr;
   logic [MEM_W-1:0]  mem_rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rdata_ff <= ring_mem[mem_raddr];
      end
   end

   // ring slot that lies a given number of entries behind the newest one
   function automatic logic [PTR_W-1:0] slot_back(input logic [PTR_W-1:0] wp,
                                                  input logic [CNT_W-1:0] back);
      logic [CNT_W:0] sum;
      begin
         sum = (CNT_W + 1)'(wp) + DEPTH_X - (CNT_W + 1)'(1) - (CNT_W + 1)'(back);
         if (sum >= DEPTH_X) begin
            sum = sum - DEPTH_X;
         end
         return sum[PTR_W-1:0];
      end
   endfunction

   // command decode helpers
   logic [CFG_W-1:0]  interval_eff;
   logic [TIME_W-1:0] elapsed;
   logic [TIME_W-1:0] rel_now;
   logic              out_free;
   logic [TIME_W-1:0] scan_time;

   assign interval_eff = (interval_ff < MIN_INTERVAL) ? MIN_INTERVAL : interval_ff;
   assign elapsed      = req_now - last_ff;
   assign rel_now      = req_now - start_ff;
   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign scan_time    = mem_rdata_ff[MEM_W-1:WORD_W];
   assign req_tready   = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         count_ff     <= '0;
         start_ff     <= '0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         count_ff     <= count_in;
         start_ff     <= start_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cutoff_ff   <= cutoff_in;
      limit_ff    <= limit_in;
      scan_ff     <= scan_in;
      back_ff     <= back_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
   end

   // next state, ring access and output loading
   always_comb begin
      logic scan_done;
      state_in     = state_ff;
      wp_in        = wp_ff;
      count_in     = count_ff;
      start_in     = start_ff;
      last_in      = last_ff;
      cutoff_in    = cutoff_ff;
      limit_in     = limit_ff;
      scan_in      = scan_ff;
      back_in      = back_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;
      mem_we       = 1'b0;
      mem_waddr    = wp_ff;
      mem_wdata    = {rel_now, req_word};
      mem_re       = 1'b0;
      mem_raddr    = slot_back(wp_ff, scan_ff);
      scan_done    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               case (req_cmd)
                  CMD_SAMPLE: begin
                     if (elapsed >= TIME_W'(interval_eff)) begin
                        mem_we  = 1'b1;
                        last_in = req_now;
                        wp_in   = (wp_ff == PTR_LAST) ? '0 : wp_ff + PTR_W'(1);
                        if (count_ff != CNT_FULL) begin
                           count_in = count_ff + CNT_W'(1);
                        end
                     end
                  end
                  CMD_READ: begin
                     cutoff_in = (rel_now >= TIME_W'(window_ff))
                                 ? rel_now - TIME_W'(window_ff) : '0;
                     limit_in  = (MAXP_W'(count_ff) < req_maxp)
                                 ? count_ff : CNT_W'(req_maxp);
                     scan_in   = '0;
                     state_in  = ST_SCAN_RD;
                  end
                  CMD_CLEAR: begin
                     wp_in    = '0;
                     count_in = '0;
                     start_in = req_now;
                     last_in  = req_now;
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN_RD: begin
            if (scan_ff == limit_ff) begin
               scan_done = 1'b1;
            end else begin
               mem_re   = 1'b1;
               state_in = ST_SCAN_CHK;
            end
         end
         ST_SCAN_CHK: begin
            if (scan_time < cutoff_ff) begin
               scan_done = 1'b1;
            end else begin
               scan_in  = scan_ff + CNT_W'(1);
               state_in = ST_SCAN_RD;
            end
         end
         ST_EMIT_RD: begin
            mem_re    = 1'b1;
            mem_raddr = slot_back(wp_ff, back_ff);
            state_in  = ST_EMIT_WAIT;
         end
         ST_EMIT_WAIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = mem_rdata_ff;
               rsp_user_in  = 1'b1;
               rsp_last_in  = (back_ff == '0);
               if (back_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  back_in  = back_ff - CNT_W'(1);
                  state_in = ST_EMIT_RD;
               end
            end
         end
         ST_EMPTY: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_user_in  = 1'b0;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // end of the walk: scan_ff holds the number of points to return (in the window, capped by the limit)
      if (scan_done) begin
         if (scan_ff == '0) begin
            state_in = ST_EMPTY;
         end else begin
            back_in  = scan_ff - CNT_W'(1);
            state_in = ST_EMIT_RD;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_data_ff[MEM_W-1:WORD_W], rsp_data_ff[WORD_W-1:0]};
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   // checks
   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_IDLE && !mem_re))
      else $error("ring written outside idle");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (count_ff <= CNT_FULL) && (wp_ff <= PTR_LAST))
      else $error("ring pointer or fill count out of range");

   a_scan_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN_RD || state_ff == ST_SCAN_CHK) |->
      (scan_ff <= limit_ff && limit_ff <= count_ff))
      else $error("window walk beyond its limit");

   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> rsp_tlast)
      else $error("empty read result without last mark");

   a_emit_back: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT_RD) |-> (back_ff < count_ff))
      else $error("emit index beyond stored points");

endmodule

@@ tb/sv/throttled_history_ring_window_read_unit_test.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// throttled_history_ring_window_read_unit_test - self-checking bench
// Drives sample, read-window, clear and unused commands into the history
// ring. An in-bench copy of the ring predicts every point a read returns.
// Each point transfer is compared field by field in order. The interval and
// window registers are rewritten between phases while the unit is idle,
// through extreme and random settings. The sender runs in random bursts.
// The receiver stalls on its own pattern and holds off once for a long
// stretch, which backs the unit up.
// ---------------------------------------------------------------------------

module throttled_history_ring_window_read_unit_test;
   import thrwr_pkg::*;

   localparam int DEPTH = RING_DEPTH_DEF;
   localparam int IDX_W = $clog2(DEPTH);

   typedef struct {
      cmd_type          cmd;
      logic [TIME_W-1:0] now;
      logic [WORD_W-1:0] word;
      logic [MAXP_W-1:0] maxp;
   } ring_cmd_type;

   typedef struct {
      logic [WORD_W-1:0] word;
      logic [TIME_W-1:0] ptime;
      logic              valid;
      logic              last;
   } ring_point_type;

   // DUT inputs start at known values
   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   logic [CMD_W-1:0]      req_tuser   = '0;
   logic                  rsp_tready  = 1'b0;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic                  req_tready;
   logic                  rsp_tvalid;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   throttled_history_ring_window_read_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // bench-side copy of the ring and its registers
   logic [WORD_W-1:0] m_words [DEPTH];
   logic [TIME_W-1:0] m_times [DEPTH];
   int                m_wptr  = 0;
   int                m_count = 0;
   logic [TIME_W-1:0] m_start = '0;
   logic [TIME_W-1:0] m_last_store = '0;
   logic [CFG_W-1:0]  m_interval = INTERVAL_RESET;
   logic [CFG_W-1:0]  m_window   = WINDOW_RESET;

   ring_cmd_type   pending_cmds [$];
   ring_point_type expected_points [$];

   int cmds_queued    = 0;
   int cmds_taken     = 0;
   int points_checked = 0;
   int reads_seen     = 0;
   int samples_stored = 0;
   int settings_run   = 1;
   int fail_count     = 0;
   logic [TIME_W-1:0] t_now = '0;

   // predict the effect of one accepted command
   task automatic ring_predict(input cmd_type cmd, input logic [TIME_W-1:0] now,
                               input logic [WORD_W-1:0] word,
                               input logic [MAXP_W-1:0] maxp);
      logic [TIME_W-1:0] eff_iv;
      logic [TIME_W-1:0] rel;
      logic [TIME_W-1:0] cutoff;
      int                lim;
      int                n;
      int                idx;
      ring_point_type    p;
      case (cmd)
         CMD_SAMPLE: begin
            eff_iv = (m_interval < MIN_INTERVAL) ? TIME_W'(MIN_INTERVAL) : TIME_W'(m_interval);
            if (TIME_W'(now - m_last_store) >= eff_iv) begin
               m_last_store               = now;
               m_words[IDX_W'(m_wptr)]    = word;
               m_times[IDX_W'(m_wptr)]    = now - m_start;
               m_wptr                     = (m_wptr + 1) % DEPTH;
               if (m_count < DEPTH) m_count++;
               samples_stored++;
            end
         end
         CMD_READ: begin
            reads_seen++;
            rel    = now - m_start;
            cutoff = (rel >= TIME_W'(m_window)) ? rel - TIME_W'(m_window) : '0;
            lim    = (m_count < int'(maxp)) ? m_count : int'(maxp);
            n      = 0;
            // walk back from the newest point, stop at the first stale one
            for (int i = 0; i < lim; i++) begin
               idx = (m_wptr + 2 * DEPTH - 1 - i) % DEPTH;
               if (m_times[IDX_W'(idx)] < cutoff) break;
               n++;
            end
            if (n == 0) begin
               p = '{word: '0, ptime: '0, valid: 1'b0, last: 1'b1};
               expected_points.push_back(p);
            end else begin
               // oldest selected point first
               for (int k = 0; k < n; k++) begin
                  idx = (m_wptr + 2 * DEPTH - 1 - (n - 1 - k)) % DEPTH;
                  p = '{word: m_words[IDX_W'(idx)], ptime: m_times[IDX_W'(idx)],
                        valid: 1'b1, last: (k == n - 1)};
                  expected_points.push_back(p);
               end
            end
         end
         CMD_CLEAR: begin
            m_wptr       = 0;
            m_count      = 0;
            m_start      = now;
            m_last_store = now;
         end
         default: ;
      endcase
   endtask

   task automatic queue_cmd(input cmd_type cmd, input logic [TIME_W-1:0] now,
                            input logic [WORD_W-1:0] word,
                            input logic [MAXP_W-1:0] maxp);
      ring_cmd_type c;
      c = '{cmd: cmd, now: now, word: word, maxp: maxp};
      pending_cmds.push_back(c);
      cmds_queued++;
   endtask

   // wait until every command is taken and every point returned
   task automatic wait_drained();
      while (cmds_taken != cmds_queued || expected_points.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   // APB write, then read back the register
   task automatic csr_write(input logic reg_sel, input logic [CFG_W-1:0] value);
      logic [CSR_DATA_W-CFG_W-1:0] junk;
      junk = (CSR_DATA_W - CFG_W)'($urandom);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_sel, 2'b00};
      csr_pwdata  <= {junk, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== CSR_DATA_W'(value)) begin
         $error("csr readback @%0h: expected %h, got %h", {reg_sel, 2'b00},
                CSR_DATA_W'(value), csr_prdata);
         fail_count++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // one setting of the registers and a run of random commands under it
   task automatic run_phase(input int n_items, input int sample_pct, input int clear_pct,
                            input logic [CFG_W-1:0] iv, input logic [CFG_W-1:0] win);
      logic [TIME_W-1:0] eff;
      logic [TIME_W-1:0] dt;
      logic [TIME_W-1:0] now_r;
      logic [MAXP_W-1:0] mp;
      cmd_type           c;
      int                r;
      int                k;
      csr_write(REG_SAMPLE_INTERVAL, iv);
      csr_write(REG_WINDOW, win);
      settings_run++;
      eff = (iv < MIN_INTERVAL) ? TIME_W'(MIN_INTERVAL) : TIME_W'(iv);
      for (int i = 0; i < n_items; i++) begin
         r = $urandom_range(0, 99);
         if (r < sample_pct) begin
            // mostly on or past the interval, some too early to store
            k = $urandom_range(0, 9);
            if (k < 2)      dt = $urandom_range(0, eff - 1);
            else if (k < 4) dt = eff;
            else            dt = eff + $urandom_range(0, eff);
            t_now = t_now + dt;
            queue_cmd(CMD_SAMPLE, t_now, $urandom, MAXP_W'($urandom));
         end else if (r < sample_pct + 30) begin
            // either near now, or with the cutoff placed among recent points
            if ($urandom_range(0, 1)) now_r = t_now + $urandom_range(0, eff);
            else now_r = t_now + TIME_W'(win) - $urandom_range(0, eff * 10);
            k = $urandom_range(0, 49);
            if (k < 3)       mp = '0;
            else if (k < 13) mp = MAXP_W'(DEPTH);
            else if (k < 30) mp = MAXP_W'($urandom_range(1, 8));
            else             mp = MAXP_W'($urandom_range(1, DEPTH));
            queue_cmd(CMD_READ, now_r, $urandom, mp);
         end else if (r < sample_pct + 30 + clear_pct) begin
            t_now = t_now + $urandom_range(0, eff);
            queue_cmd(CMD_CLEAR, t_now, $urandom, MAXP_W'($urandom));
         end else begin
            // noise: any code, any time
            c     = cmd_type'($urandom_range(0, 3));
            now_r = $urandom;
            if (c == CMD_SAMPLE || c == CMD_CLEAR) t_now = now_r;
            queue_cmd(c, now_r, $urandom, MAXP_W'($urandom_range(0, DEPTH)));
         end
      end
      wait_drained();
   endtask

   // command driver: bursts of random length, random gaps between
   ring_cmd_type drv_item;
   int           burst_left = 0;
   int           gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (gap_left > 0 || pending_cmds.size() == 0) begin
            if (gap_left > 0) gap_left <= gap_left - 1;
            req_tvalid <= 1'b0;
         end else begin
            drv_item = pending_cmds.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {1'b0, drv_item.maxp, drv_item.word, drv_item.now};
            req_tuser  <= drv_item.cmd;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 16);
               gap_left   <= $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left <= burst_left - 1;
            end
         end
      end
   end

   // point receiver: stall pattern per segment, one long hold-off
   int   seg_left  = 0;
   int   rx_mode   = 0;
   int   hold_left = 0;
   logic hold_done = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (!hold_done && points_checked >= 60) begin
         hold_done  <= 1'b1;
         hold_left  <= 400;
         rsp_tready <= 1'b0;
      end else begin
         if (seg_left == 0) begin
            seg_left <= $urandom_range(20, 200);
            rx_mode  <= $urandom_range(0, 3);
         end else begin
            seg_left <= seg_left - 1;
         end
         case (rx_mode)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= 1'($urandom_range(0, 1));
            2:       rsp_tready <= ($urandom_range(0, 3) == 0);
            default: rsp_tready <= (seg_left % 8 != 0);
         endcase
      end
   end

   // monitor: register writes, accepted commands, returned points
   ring_point_type exp_pt;

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2] == REG_SAMPLE_INTERVAL) m_interval = csr_pwdata[CFG_W-1:0];
            else if (csr_paddr[2] == REG_WINDOW)     m_window   = csr_pwdata[CFG_W-1:0];
         end
         if (req_tvalid && req_tready) begin
            ring_predict(cmd_type'(req_tuser), req_tdata[31:0], req_tdata[63:32],
                         req_tdata[70:64]);
            cmds_taken++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_points.size() == 0) begin
               $error("point transfer with nothing expected: tdata %h tuser %b tlast %b",
                      rsp_tdata, rsp_tuser, rsp_tlast);
               fail_count++;
            end else begin
               exp_pt = expected_points.pop_front();
               if (rsp_tdata[31:0] !== exp_pt.word) begin
                  $error("point_word: expected %h, got %h", exp_pt.word, rsp_tdata[31:0]);
                  fail_count++;
               end
               if (rsp_tdata[63:32] !== exp_pt.ptime) begin
                  $error("point_time: expected %h, got %h", exp_pt.ptime, rsp_tdata[63:32]);
                  fail_count++;
               end
               if (rsp_tuser !== exp_pt.valid) begin
                  $error("point_valid: expected %b, got %b", exp_pt.valid, rsp_tuser);
                  fail_count++;
               end
               if (rsp_tlast !== exp_pt.last) begin
                  $error("last_point: expected %b, got %b", exp_pt.last, rsp_tlast);
                  fail_count++;
               end
            end
            points_checked++;
         end
      end
   end

   // stimulus sequence
   initial begin
      for (int i = 0; i < DEPTH; i++) begin
         m_words[IDX_W'(i)] = '0;
         m_times[IDX_W'(i)] = '0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed, reset register values
      queue_cmd(CMD_READ,   32'd0,       32'h0,        7'd64);  // empty ring
      queue_cmd(CMD_SAMPLE, 32'd0,       32'h12345678, 7'd0);   // too soon, dropped
      queue_cmd(CMD_SAMPLE, 32'd2000,    32'hFFFF_FFFF, 7'd0);
      queue_cmd(CMD_SAMPLE, 32'd2500,    32'h0,        7'd0);   // dropped
      queue_cmd(CMD_SAMPLE, 32'd4000,    32'hA5A5_A5A5, 7'd0);
      queue_cmd(CMD_READ,   32'd4000,    32'h0,        7'd0);   // zero max points
      queue_cmd(CMD_READ,   32'd4000,    32'h0,        7'd1);
      queue_cmd(CMD_READ,   32'd4000,    32'h0,        7'd64);  // capped by fill
      queue_cmd(CMD_NONE,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'd64); // unused code
      queue_cmd(CMD_READ,   32'd607000,  32'h0,        7'd64);  // newest too old
      queue_cmd(CMD_READ,   32'd602500,  32'h0,        7'd64);  // walk stops early
      queue_cmd(CMD_CLEAR,  32'hFFFF_FF00, 32'h0,      7'd0);
      queue_cmd(CMD_READ,   32'hFFFF_FF00, 32'h0,      7'd64);  // empty after clear
      queue_cmd(CMD_SAMPLE, 32'hFFFF_FF64, 32'h0F0F_0F0F, 7'd0); // dropped
      queue_cmd(CMD_SAMPLE, 32'h0000_0800, 32'h8000_0001, 7'd0); // across time wrap
      queue_cmd(CMD_SAMPLE, 32'h0000_1000, 32'h7FFF_FFFE, 7'd0);
      queue_cmd(CMD_READ,   32'h0000_1000, 32'h0,      7'd63);
      t_now = 32'h0000_1000;
      wait_drained();

      // random phases, extremes of both registers among them
      run_phase(60,  58, 3, 27'd0,         27'd0);
      run_phase(150, 70, 0, 27'd100,       27'd86400000);
      run_phase(60,  58, 3, 27'd50,        27'd5000);
      run_phase(50,  58, 3, 27'd86400000,  27'h7FF_FFFF);
      run_phase(30,  58, 3, 27'h7FF_FFFF,  27'd1000);
      run_phase(80,  58, 3, 27'($urandom_range(100, 20000)),
                27'($urandom_range(0, 200000)));

      repeat (300) @(posedge clock);
      $display("Covered %0d commands (%0d reads, %0d samples stored) under %0d settings,",
               cmds_taken, reads_seen, samples_stored, settings_run);
      $display("and checked %0d point transfers.", points_checked);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // run limit
   initial begin
      #20000000;
      $display("Run limit reached with %0d points outstanding", expected_points.size());
      $display("== FAIL ==");
      $finish;
   end

endmodule

@@ sim.f @@
sv/thrwr_pkg.sv
sv/throttled_history_ring_window_read_unit.sv
tb/sv/throttled_history_ring_window_read_unit_test.sv
